[rtl/vdli_pkg.sv]
// ============================================================================
// vdli_pkg
// Shared types and constants for the vector display list interpreter.
// ============================================================================
package vdli_pkg;

    localparam int STACK_DEPTH   = 8;
    localparam int FRACTION_BITS = 16;
    localparam int SP_W          = $clog2(STACK_DEPTH);
    // (~lin << FRACTION_BITS) >> (8..15) always fits in FRACTION_BITS bits
    localparam int SCALE_W       = FRACTION_BITS;

    localparam logic [15:0] BASE_ADDR  = 16'h2000;
    localparam logic [31:0] CENTER_POS = 32'd512 << FRACTION_BITS;

    // opcodes, first_word[15:13]
    localparam logic [2:0] OP_LONG   = 3'd0;
    localparam logic [2:0] OP_HALT   = 3'd1;
    localparam logic [2:0] OP_SHORT  = 3'd2;
    localparam logic [2:0] OP_STAT   = 3'd3;
    localparam logic [2:0] OP_CENTER = 3'd4;
    localparam logic [2:0] OP_CALL   = 3'd5;
    localparam logic [2:0] OP_RET    = 3'd6;
    localparam logic [2:0] OP_JUMP   = 3'd7;

    // configuration register indexes
    localparam logic [1:0] CFG_COLOR_RAM = 2'd0;
    localparam logic [1:0] CFG_FLIP      = 2'd1;

    typedef struct packed {
        logic        action;
        logic [15:0] first_word;
        logic [15:0] second_word;
        logic [2:0]  random_color;
    } in_t;

    typedef struct packed {
        logic [15:0]        next_address;
        logic               done_res;
        logic               draw;
        logic               dot;
        logic signed [15:0] x_start;
        logic signed [15:0] y_start;
        logic signed [15:0] x_end;
        logic signed [15:0] y_end;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
    } out_t;

endpackage

[rtl/vector_display_list_interpreter_top.sv]
// ============================================================================
// vector_display_list_interpreter_top
// Executes one display-list instruction per input transaction and returns the
// next fetch address and the done flag, and a colored line for each draw.
// ============================================================================
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+----------------------------
//  in      | input     | in_valid / in_stall     | in_data  (vdli_pkg::in_t)
//  out     | output    | out_valid / out_stall   | out_data (vdli_pkg::out_t)
//  cfg     | input     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
//  One instruction per cycle while in_stall is low, through the stage-one and
//  result registers. Stage one decodes, updates the program state and forms
//  the scaled deltas; stage two holds the beam accumulator and loads the
//  result register. Reset clears all control state but sets the done flag;
//  the return stack is undefined until pushed. in_stall rises only when both
//  stages hold transactions and out_stall is high. cfg_ready is always high.
module vector_display_list_interpreter_top (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  vdli_pkg::in_t        in_data,
    output logic                 out_valid,
    input  logic                 out_stall,
    output vdli_pkg::out_t       out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [1:0]           cfg_index,
    input  logic [63:0]          cfg_data
);
    import vdli_pkg::*;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_DRAW   = 2'd1;
    localparam logic [1:0] KIND_CENTER = 2'd2;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] addr;
        logic        done;
        logic [31:0] dx;
        logic [31:0] dy;
        logic        dot;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } s1_t;

    // program state
    logic [15:0]        pc_reg, pc_next;
    logic [SP_W-1:0]    sp_reg, sp_next;
    logic [15:0]        stack_reg [STACK_DEPTH];
    logic               done_reg, done_next;
    logic [SCALE_W-1:0] scale_reg, scale_next;
    logic [3:0]         stat_int_reg, stat_int_next;
    logic [3:0]         color_idx_reg, color_idx_next;
    logic               sparkle_reg, sparkle_next;
    logic [31:0]        beam_x_reg, beam_y_reg;
    logic [63:0]        color_ram_reg;
    logic               flip_reg;

    // pipeline
    logic               s1_valid_reg;
    s1_t                s1_reg, s1_next;
    logic               out_valid_reg;
    out_t               out_reg, out_next;

    logic               out_load, s1_adv, in_acc;
    logic               push_en;

    // decode
    logic [15:0]             w1, w2;
    logic [2:0]              op;
    logic [15:0]             pc_inc, tgt;
    logic signed [12:0]      vec_x, vec_y;
    logic [3:0]              z_code;
    logic [7:0]              inten;
    logic signed [SCALE_W+13:0] prod_x, prod_y;
    logic [31:0]             dx, dy;
    logic [3:0]              cidx;
    logic [3:0]              inv;
    logic [SP_W-1:0]         rd_idx;
    logic [SCALE_W+7:0]      scale_wide;

    // stage two
    logic [31:0]             xe, ye;

    assign out_load  = !out_valid_reg || !out_stall;
    assign s1_adv    = s1_valid_reg && out_load;
    assign in_stall  = s1_valid_reg && !out_load;
    assign in_acc    = in_valid && !in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cfg_ready = 1'b1;

    assign w1     = in_data.first_word;
    assign w2     = in_data.second_word;
    assign op     = w1[15:13];
    assign pc_inc = pc_reg + 16'd2;
    assign tgt    = BASE_ADDR + {2'b00, w1[12:0], 1'b0};
    assign rd_idx = (sp_reg == '0) ? SP_W'(STACK_DEPTH - 1) : sp_reg - 1'b1;

    always_comb
    begin
        if (op == OP_LONG)
        begin
            vec_x  = w2[12:0];
            vec_y  = w1[12:0];
            z_code = {w2[15:13], 1'b0};
        end
        else
        begin
            vec_x  = {{7{w1[4]}}, w1[4:0], 1'b0};
            vec_y  = {{7{w1[12]}}, w1[12:8], 1'b0};
            z_code = {w1[7:5], 1'b0};
        end
        if (z_code == 4'd2)
        begin
            z_code = stat_int_reg;
        end
        inten = (z_code != 4'd0) ? {z_code[3:1], 1'b1, 4'hf} : 8'd0;
    end

    assign prod_x = vec_x * $signed({1'b0, scale_reg});
    assign prod_y = vec_y * $signed({1'b0, scale_reg});
    assign dx     = 32'(prod_x);
    assign dy     = 32'(prod_y);

    assign cidx = sparkle_reg ? {1'b0, in_data.random_color} : color_idx_reg;
    assign inv  = ~color_ram_reg[{cidx, 2'b00} +: 4];

    assign scale_wide = {~w1[7:0], {FRACTION_BITS{1'b0}}} >> (4'd8 + {1'b0, w1[10:8]});

    always_comb
    begin
        pc_next        = pc_reg;
        sp_next        = sp_reg;
        done_next      = done_reg;
        scale_next     = scale_reg;
        stat_int_next  = stat_int_reg;
        color_idx_next = color_idx_reg;
        sparkle_next   = sparkle_reg;
        push_en        = 1'b0;
        s1_next        = '0;
        s1_next.kind   = KIND_NONE;

        if (!in_data.action)
        begin
            pc_next       = BASE_ADDR;
            sp_next       = '0;
            done_next     = 1'b0;
            scale_next    = '0;
            stat_int_next = 4'd0;
        end
        else if (!done_reg)
        begin
            pc_next = pc_inc;
            case (op)
                OP_LONG, OP_SHORT:
                begin
                    if (op == OP_LONG)
                    begin
                        pc_next = pc_reg + 16'd4;
                    end
                    color_idx_next = cidx;
                    s1_next.kind   = KIND_DRAW;
                    s1_next.dx     = dx;
                    s1_next.dy     = dy;
                    s1_next.dot    = (dx == 32'd0) && (dy == 32'd0);
                    s1_next.red    = (inv[1:0] != 2'b00) ? inten : 8'd0;
                    s1_next.green  = inv[3] ? inten : 8'd0;
                    s1_next.blue   = inv[2] ? inten : 8'd0;
                end
                OP_HALT:
                begin
                    done_next = 1'b1;
                end
                OP_STAT:
                begin
                    if (w1[12])
                    begin
                        scale_next = scale_wide[SCALE_W-1:0];
                    end
                    else
                    begin
                        color_idx_next = w1[3:0];
                        stat_int_next  = w1[7:4];
                        sparkle_next   = !w1[11];
                    end
                end
                OP_CENTER:
                begin
                    s1_next.kind = KIND_CENTER;
                end
                OP_CALL:
                begin
                    if (tgt == BASE_ADDR)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        push_en = 1'b1;
                        if (sp_reg == SP_W'(STACK_DEPTH - 1))
                        begin
                            done_next = 1'b1;
                            sp_next   = '0;
                        end
                        else
                        begin
                            sp_next = sp_reg + 1'b1;
                        end
                        pc_next = tgt;
                    end
                end
                OP_RET:
                begin
                    // empty stack ends the list and wraps to the top entry
                    if (sp_reg == '0)
                    begin
                        done_next = 1'b1;
                    end
                    sp_next = rd_idx;
                    pc_next = stack_reg[rd_idx];
                end
                default:
                begin
                    if (tgt == BASE_ADDR)
                    begin
                        done_next = 1'b1;
                    end
                    else
                    begin
                        pc_next = tgt;
                    end
                end
            endcase
        end
        s1_next.addr = pc_next;
        s1_next.done = done_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= BASE_ADDR;
            sp_reg        <= '0;
            done_reg      <= 1'b1;
            scale_reg     <= '0;
            stat_int_reg  <= 4'd0;
            color_idx_reg <= 4'd0;
            sparkle_reg   <= 1'b0;
        end
        else if (in_acc)
        begin
            pc_reg        <= pc_next;
            sp_reg        <= sp_next;
            done_reg      <= done_next;
            scale_reg     <= scale_next;
            stat_int_reg  <= stat_int_next;
            color_idx_reg <= color_idx_next;
            sparkle_reg   <= sparkle_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc && push_en)
        begin
            stack_reg[sp_reg] <= pc_inc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_ram_reg <= 64'd0;
            flip_reg      <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_COLOR_RAM: color_ram_reg <= cfg_data;
                CFG_FLIP:      flip_reg      <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // stage two: beam accumulate, flip turns both deltas around
    assign xe = flip_reg ? beam_x_reg - s1_reg.dx : beam_x_reg + s1_reg.dx;
    assign ye = flip_reg ? beam_y_reg + s1_reg.dy : beam_y_reg - s1_reg.dy;

    always_comb
    begin
        out_next              = '0;
        out_next.next_address = s1_reg.addr;
        out_next.done_res     = s1_reg.done;
        if (s1_reg.kind == KIND_DRAW)
        begin
            out_next.draw    = 1'b1;
            out_next.dot     = s1_reg.dot;
            out_next.x_start = beam_x_reg[FRACTION_BITS+15:FRACTION_BITS];
            out_next.y_start = beam_y_reg[FRACTION_BITS+15:FRACTION_BITS];
            out_next.x_end   = xe[FRACTION_BITS+15:FRACTION_BITS];
            out_next.y_end   = ye[FRACTION_BITS+15:FRACTION_BITS];
            out_next.red     = s1_reg.red;
            out_next.green   = s1_reg.green;
            out_next.blue    = s1_reg.blue;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beam_x_reg <= CENTER_POS;
            beam_y_reg <= CENTER_POS;
        end
        else if (s1_adv)
        begin
            case (s1_reg.kind)
                KIND_DRAW:
                begin
                    beam_x_reg <= xe;
                    beam_y_reg <= ye;
                end
                KIND_CENTER:
                begin
                    beam_x_reg <= CENTER_POS;
                    beam_y_reg <= CENTER_POS;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_adv)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_reg <= s1_next;
        end
        if (s1_adv)
        begin
            out_reg <= out_next;
        end
    end

endmodule

[tb/sv/vector_display_list_interpreter_top_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// vector_display_list_interpreter_top_tb
// Drives display-list instructions through the interpreter with random pacing
// on both channels. A scoreboard tracks the program address, return stack,
// scale, color and beam, predicts every line and compares it field by field.
// ============================================================================
module vector_display_list_interpreter_top_tb;

    import vdli_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 100;

    // ------------------------------------------------------------------------
    // Line predictor and store of expected lines
    // ------------------------------------------------------------------------
    class beam_line_scoreboard;
        out_t        expected_lines[$];
        logic [15:0] pc;
        int unsigned sp;
        logic [15:0] ret_stack[STACK_DEPTH];
        bit          written[STACK_DEPTH];
        bit          list_done;
        logic [31:0] scale;
        logic [3:0]  stat_int;
        logic [3:0]  color_idx;
        bit          sparkle;
        logic [31:0] beam_x;
        logic [31:0] beam_y;
        logic [63:0] color_ram;
        bit          flip;
        int unsigned executed;
        int unsigned checked;
        int unsigned errors;

        function new();
            pc        = BASE_ADDR;
            sp        = 0;
            list_done = 1'b1;
            scale     = '0;
            stat_int  = '0;
            color_idx = '0;
            sparkle   = 1'b0;
            beam_x    = CENTER_POS;
            beam_y    = CENTER_POS;
            color_ram = '0;
            flip      = 1'b0;
            executed  = 0;
            checked   = 0;
            errors    = 0;
            foreach (written[k])
            begin
                written[k]   = 1'b0;
                ret_stack[k] = '0;
            end
        endfunction

        function int unsigned pending();
            return expected_lines.size();
        endfunction

        function void set_register(logic [1:0] idx, logic [63:0] val);
            if (idx == CFG_COLOR_RAM)
                color_ram = val;
            else if (idx == CFG_FLIP)
                flip = val[0];
        endfunction

        function logic [15:0] int_part(logic [31:0] v);
            logic [31:0] s;
            s = $signed(v) >>> FRACTION_BITS;
            return s[15:0];
        endfunction

        function void note_instruction(in_t it);
            out_t        res;
            logic [2:0]  op;
            logic [15:0] w1;
            logic [15:0] w2;
            logic [15:0] tgt;
            logic [31:0] x;
            logic [31:0] y;
            logic [31:0] dx;
            logic [31:0] dy;
            logic [3:0]  code;
            logic [7:0]  lvl;
            logic [3:0]  gun_en;
            res = '0;
            w1  = it.first_word;
            w2  = it.second_word;
            if (!it.action || !list_done)
                executed++;
            if (!it.action)
            begin
                pc        = BASE_ADDR;
                sp        = 0;
                list_done = 1'b0;
                scale     = '0;
                stat_int  = '0;
            end
            else if (!list_done)
            begin
                op  = w1[15:13];
                pc  = pc + 16'd2;
                tgt = BASE_ADDR + {w1[12:0], 1'b0};
                case (op)
                    OP_LONG, OP_SHORT:
                    begin
                        if (op == OP_LONG)
                        begin
                            pc   = pc + 16'd2;
                            x    = {{19{w2[12]}}, w2[12:0]};
                            y    = {{19{w1[12]}}, w1[12:0]};
                            code = {w2[15:13], 1'b0};
                        end
                        else
                        begin
                            x    = {{26{w1[4]}}, w1[4:0], 1'b0};
                            y    = {{26{w1[12]}}, w1[12:8], 1'b0};
                            code = {w1[7:5], 1'b0};
                        end
                        // code 2 borrows the intensity set by the last status
                        if (code == 4'd2)
                            code = stat_int;
                        lvl = (code != 4'd0) ? ({code, 4'hf} | 8'h1f) : 8'h00;
                        dx  = x * scale;
                        dy  = y * scale;
                        if (flip)
                        begin
                            dx = 32'd0 - dx;
                            dy = 32'd0 - dy;
                        end
                        if (sparkle)
                            color_idx = {1'b0, it.random_color};
                        gun_en = ~color_ram[{color_idx, 2'b00} +: 4];
                        res.draw    = 1'b1;
                        res.dot     = (dx == 0) && (dy == 0);
                        res.x_start = int_part(beam_x);
                        res.y_start = int_part(beam_y);
                        beam_x      = beam_x + dx;
                        beam_y      = beam_y - dy;
                        res.x_end   = int_part(beam_x);
                        res.y_end   = int_part(beam_y);
                        res.red     = (gun_en[0] || gun_en[1]) ? lvl : 8'h00;
                        res.green   = gun_en[3] ? lvl : 8'h00;
                        res.blue    = gun_en[2] ? lvl : 8'h00;
                    end
                    OP_HALT:
                        list_done = 1'b1;
                    OP_STAT:
                    begin
                        if (w1[12])
                            scale = ({24'd0, ~w1[7:0]} << FRACTION_BITS) >> (w1[10:8] + 4'd8);
                        else
                        begin
                            color_idx = w1[3:0];
                            stat_int  = w1[7:4];
                            sparkle   = !w1[11];
                        end
                    end
                    OP_CENTER:
                    begin
                        beam_x = CENTER_POS;
                        beam_y = CENTER_POS;
                    end
                    OP_CALL:
                    begin
                        if (tgt == BASE_ADDR)
                            list_done = 1'b1;
                        else
                        begin
                            ret_stack[sp] = pc;
                            written[sp]   = 1'b1;
                            // overflow: the top entry is still written, then the list ends
                            if (sp == STACK_DEPTH - 1)
                            begin
                                list_done = 1'b1;
                                sp        = 0;
                            end
                            else
                                sp++;
                            pc = tgt;
                        end
                    end
                    OP_RET:
                    begin
                        if (sp == 0)
                        begin
                            list_done = 1'b1;
                            sp        = STACK_DEPTH - 1;
                        end
                        else
                            sp--;
                        pc = ret_stack[sp];
                    end
                    default:
                    begin
                        if (tgt == BASE_ADDR)
                            list_done = 1'b1;
                        else
                            pc = tgt;
                    end
                endcase
            end
            res.next_address = pc;
            res.done_res     = list_done;
            expected_lines.push_back(res);
        endfunction

        task report(string what, logic [31:0] got, logic [31:0] want);
            errors++;
            $display("[%0t] line %0d: %s got 0x%0h, expected 0x%0h",
                     $time, checked, what, got, want);
        endtask

        task check_line(out_t got);
            out_t want;
            checked++;
            if (expected_lines.size() == 0)
            begin
                report("line with no instruction pending", got.next_address, 0);
                return;
            end
            want = expected_lines.pop_front();
            if (got.next_address !== want.next_address)
                report("next_address", got.next_address, want.next_address);
            if (got.done_res !== want.done_res)
                report("done_res", got.done_res, want.done_res);
            if (got.draw !== want.draw)
                report("draw", got.draw, want.draw);
            if (got.dot !== want.dot)
                report("dot", got.dot, want.dot);
            if (got.x_start !== want.x_start)
                report("x_start", got.x_start, want.x_start);
            if (got.y_start !== want.y_start)
                report("y_start", got.y_start, want.y_start);
            if (got.x_end !== want.x_end)
                report("x_end", got.x_end, want.x_end);
            if (got.y_end !== want.y_end)
                report("y_end", got.y_end, want.y_end);
            if (got.red !== want.red)
                report("red", got.red, want.red);
            if (got.green !== want.green)
                report("green", got.green, want.green);
            if (got.blue !== want.blue)
                report("blue", got.blue, want.blue);
        endtask
    endclass

    // ------------------------------------------------------------------------
    // DUT and signals
    // ------------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_t         in_data;
    logic        out_valid;
    logic        out_stall;
    out_t        out_data;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    beam_line_scoreboard line_sb = new();
    int unsigned         in_pace;
    int unsigned         out_pace;
    int unsigned         cycle_count;

    vector_display_list_interpreter_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial cycle_count = 0;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("FAILURE");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------------
    // pace 0: back to back, 1: random waits, 2: mostly back to back
    function automatic int unsigned draw_wait(int unsigned pace);
        if (pace == 0)
            return 0;
        if (pace == 1)
            return $urandom_range(0, 12);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(1, 12) : 0;
    endfunction

    function automatic in_t instr(logic [2:0] op, logic [12:0] low, logic [15:0] w2,
                                  logic [2:0] rc);
        in_t it;
        it.action       = 1'b1;
        it.first_word   = {op, low};
        it.second_word  = w2;
        it.random_color = rc;
        return it;
    endfunction

    function automatic in_t start_item();
        in_t it;
        it              = in_t'({$urandom, $urandom});
        it.action       = 1'b0;
        return it;
    endfunction

    function automatic in_t rand_instr(logic [2:0] op);
        logic [12:0] low;
        low = 13'($urandom);
        // now and then aim a call or jump at the list base
        if ((op == OP_CALL || op == OP_JUMP) && $urandom_range(0, 15) == 0)
            low = '0;
        return instr(op, low, 16'($urandom), 3'($urandom));
    endfunction

    // 0: drawing, 1: balanced calls and returns, 2: deep nesting
    function automatic logic [2:0] pick_op(int unsigned profile);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (profile == 2)
        begin
            if (r < 60) return OP_CALL;
            if (r < 72) return OP_RET;
            if (r < 82) return OP_SHORT;
            if (r < 90) return OP_STAT;
            return OP_LONG;
        end
        if (profile == 1)
        begin
            if (r < 38) return OP_CALL;
            if (r < 70) return OP_RET;
            if (r < 78) return OP_JUMP;
            if (r < 88) return OP_SHORT;
            if (r < 93) return OP_LONG;
            if (r < 97) return OP_STAT;
            return OP_CENTER;
        end
        if (r < 28) return OP_LONG;
        if (r < 56) return OP_SHORT;
        if (r < 74) return OP_STAT;
        if (r < 80) return OP_CENTER;
        if (r < 87) return OP_CALL;
        if (r < 94) return OP_RET;
        if (r < 98) return OP_JUMP;
        return OP_HALT;
    endfunction

    // Entered right after a rising edge; returns at the edge that accepts the item.
    task automatic send_instr(input in_t it);
        int unsigned gap;
        gap = draw_wait(in_pace);
        // a return on an empty stack must not read a slot that was never pushed
        if (it.action && !line_sb.list_done && it.first_word[15:13] == OP_RET &&
            line_sb.sp == 0 && !line_sb.written[STACK_DEPTH-1])
            it.first_word[15:13] = OP_CALL;
        @(negedge clk);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        line_sb.note_instruction(it);
    endtask

    task automatic stop_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (line_sb.pending() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        line_sb.set_register(idx, val);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic reconfigure(input logic [63:0] colors, input logic flip_val);
        stop_input();
        wait_drain();
        repeat (4) @(negedge clk);
        write_reg(CFG_COLOR_RAM, colors);
        write_reg(CFG_FLIP, {63'd0, flip_val});
    endtask

    // ------------------------------------------------------------------------
    // Result side: random stall, check every accepted transaction
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned hold;
        hold      = 0;
        out_pace  = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
            begin
                line_sb.check_line(out_data);
                hold = draw_wait(out_pace);
                if ($urandom_range(0, 39) == 0)
                    out_pace = $urandom_range(0, 2);
            end
            @(negedge clk);
            out_stall <= (hold != 0);
            if (hold != 0)
                hold--;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        int unsigned phase;
        int unsigned profile;
        int unsigned len;
        int unsigned goal;
        logic [63:0] colors;
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        in_pace   = 0;
        repeat (2) @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_reg(CFG_COLOR_RAM, 64'd0);
        write_reg(CFG_FLIP, 64'd0);

        // directed: idle list, vector extremes, status, scale, sparkle, flow control
        in_pace = 1;
        send_instr(instr(OP_LONG, 13'h1fff, 16'hffff, 3'd7));
        send_instr(start_item());
        send_instr(instr(OP_SHORT, 13'h0000, 16'h0000, 3'd0));
        send_instr(instr(OP_STAT, 13'h08a5, 16'h0000, 3'd0));
        send_instr(instr(OP_STAT, 13'h1000, 16'h0000, 3'd0));
        send_instr(instr(OP_LONG, 13'h0fff, 16'hf000, 3'd0));
        send_instr(instr(OP_LONG, 13'h1000, 16'h2fff, 3'd0));
        send_instr(instr(OP_SHORT, 13'h0ff0, 16'h0000, 3'd0));
        send_instr(instr(OP_CENTER, 13'h1fff, 16'h0000, 3'd0));
        send_instr(instr(OP_STAT, 13'h0032, 16'h0000, 3'd0));
        send_instr(instr(OP_SHORT, 13'h1123, 16'h0000, 3'd7));
        send_instr(instr(OP_JUMP, 13'h0100, 16'h0000, 3'd0));
        send_instr(instr(OP_CALL, 13'h0040, 16'h0000, 3'd0));
        send_instr(instr(OP_RET, 13'h1fff, 16'h0000, 3'd0));
        send_instr(instr(OP_CALL, 13'h0000, 16'h0000, 3'd0));
        send_instr(start_item());
        for (int k = 1; k <= STACK_DEPTH; k++)
            send_instr(instr(OP_CALL, 13'(k), 16'h0000, 3'd0));
        send_instr(start_item());
        send_instr(instr(OP_RET, 13'h0000, 16'h0000, 3'd0));
        send_instr(start_item());
        send_instr(instr(OP_JUMP, 13'h0000, 16'h0000, 3'd0));
        send_instr(start_item());
        send_instr(instr(OP_HALT, 13'h1fff, 16'hffff, 3'd0));

        // random programs, one register setting per phase
        for (phase = 0; phase < 5; phase++)
        begin
            colors = {$urandom, $urandom};
            case (phase)
                0: reconfigure(64'hffff_ffff_ffff_ffff, 1'b1);
                1: reconfigure(colors, 1'b0);
                2: reconfigure(colors, 1'b1);
                3: reconfigure(colors, 1'($urandom));
                default: reconfigure(64'd0, 1'b1);
            endcase
            goal = line_sb.executed + PHASE_ITEMS;
            while (line_sb.executed < goal)
            begin
                profile = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 2) : 0;
                in_pace = $urandom_range(0, 2);
                if ($urandom_range(0, 9) == 0)
                begin
                    stop_input();
                    wait_drain();
                end
                if ($urandom_range(0, 9) != 0)
                    send_instr(start_item());
                len = $urandom_range(1, 30);
                for (int k = 0; k < len && !line_sb.list_done; k++)
                    send_instr(rand_instr(pick_op(profile)));
                if (!line_sb.list_done && $urandom_range(0, 1) == 0)
                    send_instr(rand_instr(OP_HALT));
                // noise: fully random transactions, mostly landing on an ended list
                if ($urandom_range(0, 7) == 0)
                    repeat ($urandom_range(1, 3))
                        send_instr(in_t'({$urandom, $urandom}));
            end
        end

        stop_input();
        wait_drain();
        repeat (8) @(negedge clk);
        if (line_sb.errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
